// ===== rtl/core/fed_pkg.sv =====
// ----------------------------------------------------------------------------
// fed_pkg - shared types and constants for the feedback echo delay
// Holds the register map, the reset values and the control bundle that the
// position controller hands to the datapath.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int MAX_DELAY_FRAMES_DEF = 16384;
  localparam int SAMPLE_BITS_DEF      = 24;

  localparam int DELAY_W = 15;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 16;
  localparam int GAIN_SHIFT = 15;

  localparam logic [DELAY_W-1:0] DELAY_RST    = DELAY_W'(2205);
  localparam logic [GAIN_W-1:0]  FEEDBACK_RST = GAIN_W'(12288);
  localparam logic [GAIN_W-1:0]  WET_RST      = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]  DRY_RST      = GAIN_W'(32768);

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WET      = 2'd2,
    REG_DRY      = 2'd3
  } fed_reg_t;

  // per-cycle control from the position controller to the datapath
  typedef struct packed {
    logic adv;     // pipeline moves this cycle
    logic acc;     // input transfer this cycle
    logic wr_en;   // item in stage 2 writes its ring entry this cycle
    logic rd_hit;  // entry read for the new item has been written before
    logic rd_fwd;  // new item reads the entry being written right now
  } fed_ctl_t;

endpackage

// ===== rtl/core/fed_stream_if.sv =====
// ----------------------------------------------------------------------------
// fed_stream_if - sample channels of the feedback echo delay
// Valid/ready channels, one carrying input samples and one carrying results.
// ----------------------------------------------------------------------------
interface fed_in_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fed_out_if #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/feedback_echo_delay_top.sv =====
// ----------------------------------------------------------------------------
// feedback_echo_delay_top - feedback echo on an interleaved stereo stream
// Mixes each sample with its delayed copy and feeds the echo back into a ring.
// ----------------------------------------------------------------------------
// Each transferred sample gives one result, dry*x + wet*ring[pos], and the
// ring entry becomes feedback*ring[pos] + x, both saturated to SAMPLE_BITS;
// gains are unsigned with 32768 as unity and products are floored after the
// 15-bit shift. The block takes one sample every clock cycle while the output
// is not stalled; the result passes through the ring read on the transfer
// edge, then multiply, then mix and saturate, and a stalled output holds the
// whole pipeline. The ring sits in one ram with one read and one write port;
// a sample that reads the entry being written in the same cycle gets the new
// value forwarded. The ring starts out silent without a clearing pass: a fill
// mark tracks how much of it has been written since reset, and reads beyond
// it return zero, so samples are accepted from the first cycle after reset.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while the block is idle, which the block itself does not enforce.
// Writing the delay length restarts the ring position at zero.
module feedback_echo_delay_top #(
  parameter int MAX_DELAY_FRAMES = fed_pkg::MAX_DELAY_FRAMES_DEF,
  parameter int SAMPLE_BITS      = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  fed_in_if.sink                   in_chan,
  fed_out_if.source                out_chan,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [fed_pkg::CFG_W-1:0] cfg_wdata
);
  import fed_pkg::*;

  localparam int DEPTH = 2 * MAX_DELAY_FRAMES;
  localparam int PW    = $clog2(DEPTH);

  // configuration registers
  logic [DELAY_W-1:0] delay_r;
  logic [GAIN_W-1:0]  feedback_r, wet_r, dry_r;
  logic               pos_clr;

  // ring access
  logic [PW-1:0]          rd_addr, wr_addr;
  logic [SAMPLE_BITS-1:0] ram_q, wr_data;
  fed_ctl_t               ctl;

  // register decode; a delay write also restarts the position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= DELAY_RST;
      feedback_r <= FEEDBACK_RST;
      wet_r      <= WET_RST;
      dry_r      <= DRY_RST;
    end else if (cfg_we) begin
      unique case (fed_reg_t'(cfg_index))
        REG_DELAY:    delay_r    <= cfg_wdata[DELAY_W-1:0];
        REG_FEEDBACK: feedback_r <= cfg_wdata[GAIN_W-1:0];
        REG_WET:      wet_r      <= cfg_wdata[GAIN_W-1:0];
        REG_DRY:      dry_r      <= cfg_wdata[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  assign pos_clr = cfg_we && (fed_reg_t'(cfg_index) == REG_DELAY);

  // position, fill mark, pipeline valids and forwarding
  fed_ctrl #(
    .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .delay_frames (delay_r),
    .pos_clr      (pos_clr),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .ctl          (ctl)
  );

  // echo ring, read on each input transfer, written as the item leaves mixing
  fed_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.acc),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // gain products, mix and saturation
  fed_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .ctl           (ctl),
    .sample_in     (in_chan.sample_in),
    .feedback_gain (feedback_r),
    .wet_gain      (wet_r),
    .dry_gain      (dry_r),
    .ram_q         (ram_q),
    .wr_data       (wr_data),
    .sample_out    (out_chan.sample_out)
  );

  // forwarding only ever covers a write-back in the same cycle as the read
  a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_fwd |-> (ctl.acc && ctl.wr_en && (wr_addr == rd_addr)))
    else $error("forward without a matching ring write");

  // a held result blocks new input transfers
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> (!in_chan.ready && !ctl.wr_en))
    else $error("pipeline moved while the output was stalled");

  // a delay length write restarts the ring at entry zero
  a_delay_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pos_clr |=> (rd_addr == '0))
    else $error("ring position not restarted after delay write");

endmodule

// ===== rtl/core/fed_ram.sv =====
// ----------------------------------------------------------------------------
// fed_ram - generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fed_ctrl.sv =====
// ----------------------------------------------------------------------------
// fed_ctrl - ring position, fill mark and pipeline control
// Tracks the ring position, the written prefix of the ring, the valid bits of
// the pipeline and the read-after-write forwarding decision.
// ----------------------------------------------------------------------------
module fed_ctrl #(
  parameter int MAX_DELAY_FRAMES = fed_pkg::MAX_DELAY_FRAMES_DEF,
  localparam int PW = $clog2(2 * MAX_DELAY_FRAMES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [fed_pkg::DELAY_W-1:0]  delay_frames,
  input  logic                         pos_clr,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PW-1:0]                rd_addr,
  output logic [PW-1:0]                wr_addr,
  output fed_pkg::fed_ctl_t            ctl
);
  import fed_pkg::*;

  localparam int LEN_W = PW + 1;

  logic [PW-1:0]    frames;
  logic [LEN_W-1:0] ring_len;
  logic [PW-1:0]    pos_r, pos_nxt, pos_cur;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             s1_v_r, s2_v_r, out_v_r;
  logic [PW-1:0]    s1_pos_r, s2_pos_r;
  logic             adv, acc, wr_en;

  // clamp the delay to 1..MAX and double it for two channels
  always_comb begin
    if (delay_frames == '0) begin
      frames = PW'(1);
    end else if (32'(delay_frames) > 32'(MAX_DELAY_FRAMES)) begin
      frames = PW'(MAX_DELAY_FRAMES);
    end else begin
      frames = PW'(delay_frames);
    end
    ring_len = {frames, 1'b0};
  end

  always_comb begin
    pos_cur = ({1'b0, pos_r} >= ring_len) ? '0 : pos_r;
    pos_inc = {1'b0, pos_cur} + LEN_W'(1);
    pos_nxt = (pos_inc >= ring_len) ? '0 : pos_inc[PW-1:0];
  end

  assign adv   = !out_v_r || out_ready;
  assign acc   = in_valid && adv;
  assign wr_en = adv && s2_v_r;

  // entries are written in order from zero, so the written part is a prefix
  assign fill_nxt = (wr_en && ({1'b0, s2_pos_r} == fill_r)) ? fill_r + LEN_W'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fill_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (pos_clr) begin
        pos_r <= '0;
      end else if (acc) begin
        pos_r <= pos_nxt;
      end
      if (adv) begin
        s1_v_r  <= acc;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos_r <= pos_cur;
      s2_pos_r <= s1_pos_r;
    end
  end

  assign in_ready   = adv;
  assign out_valid  = out_v_r;
  assign rd_addr    = pos_cur;
  assign wr_addr    = s2_pos_r;
  assign ctl.adv    = adv;
  assign ctl.acc    = acc;
  assign ctl.wr_en  = wr_en;
  assign ctl.rd_hit = {1'b0, pos_cur} < fill_r;
  assign ctl.rd_fwd = acc && wr_en && (s2_pos_r == pos_cur);

endmodule

// ===== rtl/core/fed_dp.sv =====
// ----------------------------------------------------------------------------
// fed_dp - echo arithmetic
// Selects the ring value, forms the three gain products, then mixes and
// saturates the output and the value written back to the ring.
// ----------------------------------------------------------------------------
module fed_dp #(
  parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  fed_pkg::fed_ctl_t              ctl,
  input  logic signed [SAMPLE_BITS-1:0]  sample_in,
  input  logic [fed_pkg::GAIN_W-1:0]     feedback_gain,
  input  logic [fed_pkg::GAIN_W-1:0]     wet_gain,
  input  logic [fed_pkg::GAIN_W-1:0]     dry_gain,
  input  logic [SAMPLE_BITS-1:0]         ram_q,
  output logic [SAMPLE_BITS-1:0]         wr_data,
  output logic signed [SAMPLE_BITS-1:0]  sample_out
);
  import fed_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int SH_W   = PROD_W - GAIN_SHIFT;
  localparam int SUM_W  = SH_W + 1;

  logic signed [SAMPLE_BITS-1:0] s1_sample_r, s2_sample_r;
  logic                          s1_hit_r, s1_fwd_r;
  logic [SAMPLE_BITS-1:0]        s1_fwd_data_r;
  logic signed [SAMPLE_BITS-1:0] ring_val;
  logic signed [GAIN_W:0]        fb_g, wet_g, dry_g;
  logic signed [PROD_W-1:0]      fb_p_nxt, wet_p_nxt, dry_p_nxt;
  logic signed [PROD_W-1:0]      fb_p_r, wet_p_r, dry_p_r;
  logic signed [SH_W-1:0]        fb_sh, wet_sh, dry_sh;
  logic signed [SUM_W-1:0]       mix_sum, fb_sum;
  logic signed [SAMPLE_BITS-1:0] out_r, out_nxt;

  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-SAMPLE_BITS:0] top;
    top = v[SUM_W-1:SAMPLE_BITS-1];
    if ((top == '0) || (top == '1)) begin
      sat = v[SAMPLE_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // stage 1: ring value and products
  always_comb begin
    if (s1_fwd_r) begin
      ring_val = s1_fwd_data_r;
    end else if (s1_hit_r) begin
      ring_val = ram_q;
    end else begin
      ring_val = '0;
    end
    fb_g      = {1'b0, feedback_gain};
    wet_g     = {1'b0, wet_gain};
    dry_g     = {1'b0, dry_gain};
    fb_p_nxt  = fb_g * ring_val;
    wet_p_nxt = wet_g * ring_val;
    dry_p_nxt = dry_g * s1_sample_r;
  end

  // stage 2: floor shift, add, saturate
  always_comb begin
    fb_sh   = fb_p_r[PROD_W-1:GAIN_SHIFT];
    wet_sh  = wet_p_r[PROD_W-1:GAIN_SHIFT];
    dry_sh  = dry_p_r[PROD_W-1:GAIN_SHIFT];
    mix_sum = SUM_W'(dry_sh) + SUM_W'(wet_sh);
    fb_sum  = SUM_W'(fb_sh) + SUM_W'(s2_sample_r);
    out_nxt = sat(mix_sum);
    wr_data = sat(fb_sum);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_sample_r   <= sample_in;
      s1_hit_r      <= ctl.rd_hit;
      s1_fwd_r      <= ctl.rd_fwd;
      s1_fwd_data_r <= wr_data;
      s2_sample_r   <= s1_sample_r;
      fb_p_r        <= fb_p_nxt;
      wet_p_r       <= wet_p_nxt;
      dry_p_r       <= dry_p_nxt;
      out_r         <= out_nxt;
    end
  end

  assign sample_out = out_r;

endmodule

// ===== test/feedback_echo_delay_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_top_tb - self-checking bench for the feedback echo delay
// Streams signed samples through the block under random sender bursts and
// receiver stalls, predicts every mixed output with a cycle-free model of
// the echo ring and compares each result in order of transfer.
// ----------------------------------------------------------------------------
module feedback_echo_delay_top_tb;
  import fed_pkg::*;

  localparam int SBITS       = SAMPLE_BITS_DEF;
  localparam int MAX_FRAMES  = MAX_DELAY_FRAMES_DEF;
  localparam int SETTLE      = 8;     // idle cycles after the last result
  localparam int LONG_HOLD   = 200;   // receiver hold-off that backs up the pipeline
  localparam int STALL_LIMIT = 4000;  // cycles without any transfer before giving up
  localparam int RAND_PHASES = 13;

  typedef logic signed [SBITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = sample_t'((longint'(1) <<< (SBITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(longint'(1) <<< (SBITS - 1)));

  // one register setting; only fields whose flag is set get written
  typedef struct {
    bit                set_delay;
    bit                set_fb;
    bit                set_wet;
    bit                set_dry;
    logic [CFG_W-1:0]  delay;
    logic [CFG_W-1:0]  fb;
    logic [CFG_W-1:0]  wet;
    logic [CFG_W-1:0]  dry;
  } echo_setting_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

  // echo ring predictor and queue of expected mixed samples
  class echo_scoreboard;
    sample_t            ring_mem [2*MAX_FRAMES];
    int unsigned        ring_pos;
    logic [DELAY_W-1:0] delay_frames;
    logic [GAIN_W-1:0]  fb_gain;
    logic [GAIN_W-1:0]  wet_gain;
    logic [GAIN_W-1:0]  dry_gain;
    sample_t            expected_out [$];
    int unsigned        n_in, n_checked, n_errors, n_out_clip, n_ring_clip, n_wraps;

    function new();
      foreach (ring_mem[i]) ring_mem[i] = '0;
      ring_pos     = 0;
      delay_frames = DELAY_RST;
      fb_gain      = FEEDBACK_RST;
      wet_gain     = WET_RST;
      dry_gain     = DRY_RST;
      n_in = 0; n_checked = 0; n_errors = 0;
      n_out_clip = 0; n_ring_clip = 0; n_wraps = 0;
    endfunction

    function void set_reg(fed_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DELAY: begin
          delay_frames = val[DELAY_W-1:0];
          ring_pos     = 0;  // ring contents stay
        end
        REG_FEEDBACK: fb_gain  = val;
        REG_WET:      wet_gain = val;
        REG_DRY:      dry_gain = val;
      endcase
    endfunction

    function int unsigned ring_len();
      int unsigned f;
      f = delay_frames;
      if (f < 1) f = 1;
      if (f > MAX_FRAMES) f = MAX_FRAMES;
      return 2 * f;
    endfunction

    // gain times value, arithmetic shift gives the floor
    function longint scaled(logic [GAIN_W-1:0] g, longint v);
      return (longint'(g) * v) >>> GAIN_SHIFT;
    endfunction

    function longint clamp(longint v);
      if (v > longint'(SAMPLE_MAX)) return longint'(SAMPLE_MAX);
      if (v < longint'(SAMPLE_MIN)) return longint'(SAMPLE_MIN);
      return v;
    endfunction

    function void note_sample(sample_t s);
      int unsigned len, p;
      longint      x, r, mix, fbv;
      len = ring_len();
      p   = ring_pos;
      if (p >= len) p = 0;
      x   = longint'(s);
      r   = longint'(ring_mem[p]);
      mix = scaled(dry_gain, x) + scaled(wet_gain, r);
      fbv = scaled(fb_gain, r) + x;
      if (mix != clamp(mix)) n_out_clip++;
      if (fbv != clamp(fbv)) n_ring_clip++;
      expected_out.push_back(sample_t'(clamp(mix)));
      ring_mem[p] = sample_t'(clamp(fbv));
      p++;
      if (p >= len) begin
        p = 0;
        n_wraps++;
      end
      ring_pos = p;
      n_in++;
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (expected_out.size() == 0) begin
        n_errors++;
        $display("%0t sample_out %0d arrived with nothing expected", $time, got);
        return;
      end
      want = expected_out.pop_front();
      n_checked++;
      if (got !== want) begin
        n_errors++;
        $display("%0t sample_out mismatch: expected %0d actual %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  fed_in_if  in_chan ();
  fed_out_if out_chan ();

  echo_scoreboard sb = new();

  int burst_left = 0;     // transfers left in the current sender burst
  bit hold_off_req = 0;   // asks the receiver for one long hold-off
  int n_settings = 0;

  feedback_echo_delay_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driving tasks, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one sample transfer; a new burst may start with a random gap
  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      // about a quarter of bursts follow straight on, no idle at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.sample_in <= s;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  // drop valid, wait for every expected result, then let the pipe go quiet
  task automatic drain_idle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input fed_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // back-to-back writes keep cfg_we high, it drops once after the last one
  task automatic configure(input echo_setting_t st);
    if (st.set_delay) write_reg(REG_DELAY, st.delay);
    if (st.set_fb)    write_reg(REG_FEEDBACK, st.fb);
    if (st.set_wet)   write_reg(REG_WET, st.wet);
    if (st.set_dry)   write_reg(REG_DRY, st.dry);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic play_list(input sample_t vals[$]);
    foreach (vals[i]) send_sample(vals[i]);
    drain_idle();
  endtask

  // ---------------------------------------------------------------------------
  // random content
  // ---------------------------------------------------------------------------

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2, 3:    return '1;
      4, 5, 6: return CFG_W'(32768);
      default: return CFG_W'($urandom());
    endcase
  endfunction

  // per-phase setting; a few phases are pinned to the extremes
  function automatic echo_setting_t pick_setting(int ph);
    echo_setting_t st;
    st.set_delay = (ph inside {0, 3, 4, 7, 8, 10}) || ($urandom_range(0, 9) < 6);
    st.set_fb    = (ph == 0) || ($urandom_range(0, 4) != 0);
    st.set_wet   = (ph == 0) || ($urandom_range(0, 4) != 0);
    st.set_dry   = (ph == 0) || ($urandom_range(0, 4) != 0);
    st.delay     = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 300))
                                              : CFG_W'($urandom_range(1, 24));
    st.fb        = rand_gain();
    st.wet       = rand_gain();
    st.dry       = rand_gain();
    case (ph)
      1: begin  // echo muted, dry at its top
        st.set_wet = 1; st.wet = '0;
        st.set_dry = 1; st.dry = '1;
      end
      2: begin  // dry muted, loud wet with runaway feedback
        st.set_dry = 1; st.dry = '0;
        st.set_wet = 1; st.wet = '1;
        st.set_fb  = 1; st.fb  = '1;
      end
      3:  st.delay = CFG_W'(MAX_FRAMES);
      7:  st.delay = '1;       // masked to 15 bits, then past the maximum
      10: st.delay = CFG_W'(1);
      default: ;
    endcase
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: ready follows a randomly chosen mode, picked anew when the current one runs out
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       cyc;
    bit       rdy;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    cyc       = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_off_req) begin
        hold_off_req = 0;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left != 0) begin
        // long hold-off, the sender keeps offering until the block backs up
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_EVERY4: rdy = (cyc % 4) != 3;
          default:   rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_chan.ready <= rdy;
    end
  end

  // every result transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result(out_chan.sample_out);
  end

  // watchdog on transfers in either direction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    echo_setting_t st;
    sample_t       vals[$];
    int            n_items;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_DELAY;
    cfg_wdata         <= '0;
    in_chan.valid     <= 1'b0;
    in_chan.sample_in <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: unity dry and wet over a silent ring, so output = input
    vals = '{SAMPLE_MAX, SAMPLE_MIN, sample_t'(-1), sample_t'(0)};
    play_list(vals);

    // one-frame delay, every gain at its top: output and stored value clip
    st = '{1, 1, 1, 1, CFG_W'(1), '1, '1, '1};
    configure(st);
    vals = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, sample_t'(1), sample_t'(-1)};
    play_list(vals);

    // gains only, position carries on; smallest dry gain shows the floor
    st = '{0, 1, 1, 1, '0, '0, CFG_W'(32768), CFG_W'(1)};
    configure(st);
    vals = '{sample_t'(0), sample_t'(0), sample_t'(-1), sample_t'(1),
             sample_t'(32767), sample_t'(-32769)};
    play_list(vals);

    // zero delay length acts as one frame and restarts the position
    st = '{1, 0, 0, 0, '0, '0, '0, '0};
    configure(st);
    vals = '{sample_t'(100), sample_t'(-100), sample_t'(0), sample_t'(0)};
    play_list(vals);

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      st = pick_setting(ph);
      configure(st);
      // huge rings never wrap within a phase, keep those short
      n_items = (sb.ring_len() > 1000) ? 40 : 55;
      if (ph == 5) hold_off_req = 1;
      for (int i = 0; i < n_items; i++) send_sample(rand_sample());
      drain_idle();
    end

    $display("covered %0d samples over %0d register settings, %0d ring wraps",
             sb.n_in, n_settings, sb.n_wraps);
    $display("clipping hit %0d outputs and %0d ring writes, %0d results compared",
             sb.n_out_clip, sb.n_ring_clip, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors, %0d results never arrived", sb.n_errors, sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
